/* rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// Types and constants shared by the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int ROW_W = 13;

    localparam logic [10:0] FRAME_W_RESET = 11'd640;
    localparam logic [11:0] FRAME_H_RESET = 12'd480;

    // register indexes on the config port
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // squares above this give a rounded root of 256 or more
    localparam logic [20:0] MAG_LIMIT = 21'd65280;
    localparam logic [7:0]  MAG_SAT   = 8'd255;

    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic [10:0] w;
        logic [11:0] h;
    } frame_size_t;

    // border-masked 3x3 window, index = row * 3 + column
    typedef struct packed {
        rgb_t [8:0] win;
        logic       fend;
    } work_t;

    typedef struct packed {
        logic  push;
        work_t data;
    } q_push_t;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_SQ,
        B_ROOT,
        B_OUT
    } back_state_t;

endpackage

/* rtl/sem_ifs.sv */
// ----------------------------------------------------------------------------
// sem_ifs
// Pixel and edge stream channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sem_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       filler;

    modport source (output valid, red_in, green_in, blue_in, filler, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, filler, output ready);
endinterface

interface sem_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_end;

    modport source (output valid, red_edge, green_edge, blue_edge, frame_end, input ready);
    modport sink   (input valid, red_edge, green_edge, blue_edge, frame_end, output ready);
endinterface

/* rtl/sem_front.sv */
// ----------------------------------------------------------------------------
// sem_front
// Accepts pixels, runs the line stores and window, classifies each position.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sem_pix_if.sink              pix_in,
    input  sem_pkg::frame_size_t size,
    input  logic                 q_full,
    output sem_pkg::q_push_t     q_push
);

    localparam int CW = $clog2(MAX_WIDTH);

    sem_pkg::front_state_t state_reg, state_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0] row_reg, row_next;
    sem_pkg::rgb_t            pix_reg;
    sem_pkg::rgb_t            up_rd_reg;
    sem_pkg::rgb_t            mid_rd_reg;
    sem_pkg::rgb_t [8:0]      win_reg, win_next;

    sem_pkg::rgb_t upper_mem  [MAX_WIDTH];
    sem_pkg::rgb_t middle_mem [MAX_WIDTH];

    logic        accept, flushing, take;
    logic [13:0] colx, w14, ccol, colinc;
    logic [sem_pkg::ROW_W-1:0] crow;
    logic        emit, mtop, mbot, mleft, mright, fend, wrap;
    sem_pkg::rgb_t [8:0] win_masked;

    assign pix_in.ready = (state_reg == sem_pkg::F_IDLE) && !q_full;
    assign accept   = pix_in.valid && pix_in.ready;
    assign flushing = row_reg >= {1'b0, size.h};
    assign take     = accept && !(pix_in.filler && !flushing);

    // line stores: read on take, write back during the update cycle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            up_rd_reg <= upper_mem[col_reg];
        end
        if (state_reg == sem_pkg::F_UPD)
        begin
            upper_mem[col_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mid_rd_reg <= middle_mem[col_reg];
            pix_reg    <= flushing ? 24'd0
                                   : {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
        end
        if (state_reg == sem_pkg::F_UPD)
        begin
            middle_mem[col_reg] <= pix_reg;
        end
    end

    always_comb
    begin
        colx   = 14'(col_reg);
        w14    = 14'(size.w);
        emit   = (row_reg >= 13'd2) || ((row_reg >= 13'd1) && (colx != 14'd0));
        if (colx == 14'd0)
        begin
            crow = (row_reg >= 13'd2) ? row_reg - 13'd2 : 13'd0;
            ccol = w14 - 14'd1;
        end
        else
        begin
            crow = (row_reg >= 13'd1) ? row_reg - 13'd1 : row_reg;
            ccol = colx - 14'd1;
        end
        mtop   = crow == 13'd0;
        mbot   = ({1'b0, crow} + 14'd1) >= {2'b00, size.h};
        mleft  = ccol == 14'd0;
        mright = (ccol + 14'd1) >= w14;
        fend   = mbot && mright;
        colinc = colx + 14'd1;
        wrap   = colinc >= w14;

        for (int r = 0; r < 3; r++)
        begin
            win_next[r * 3]     = win_reg[r * 3 + 1];
            win_next[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_next[2] = up_rd_reg;
        win_next[5] = mid_rd_reg;
        win_next[8] = pix_reg;

        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && mtop) || (r == 2 && mbot) || (c == 0 && mleft) ||
                    (c == 2 && mright))
                begin
                    win_masked[r * 3 + c] = 24'd0;
                end
                else
                begin
                    win_masked[r * 3 + c] = win_next[r * 3 + c];
                end
            end
        end

        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            sem_pkg::F_IDLE:
            begin
                if (take)
                begin
                    state_next = sem_pkg::F_UPD;
                end
            end
            sem_pkg::F_UPD:
            begin
                state_next = sem_pkg::F_IDLE;
                if (wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + 13'd1;
                end
                else
                begin
                    col_next = colinc[CW-1:0];
                end
                if (emit && fend)
                begin
                    col_next = '0;
                    row_next = '0;
                end
            end
            default:
            begin
                state_next = sem_pkg::F_IDLE;
            end
        endcase

        q_push.push      = (state_reg == sem_pkg::F_UPD) && emit;
        q_push.data.win  = win_masked;
        q_push.data.fend = fend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (state_reg == sem_pkg::F_UPD)
            begin
                win_reg <= win_next;
            end
        end
    end

endmodule

/* rtl/sem_fifo.sv */
// ----------------------------------------------------------------------------
// sem_fifo
// Two-entry queue of classified windows between front and back.
// ----------------------------------------------------------------------------
module sem_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  sem_pkg::q_push_t q_push,
    input  logic             pop,
    output sem_pkg::work_t   pop_data,
    output logic             full,
    output logic             empty
);

    sem_pkg::work_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (q_push.push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, q_push.push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/sem_back.sv */
// ----------------------------------------------------------------------------
// sem_back
// Sobel sums, squares and a bit-serial rounded root for three channels.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    output logic           pop,
    input  sem_pkg::work_t pop_data,
    sem_edge_if.source     edge_out
);

    sem_pkg::back_state_t state_reg, state_next;
    sem_pkg::work_t       work_reg;
    logic [9:0]  gx_reg   [3];
    logic [9:0]  gy_reg   [3];
    logic [15:0] s_reg    [3];
    logic        big_reg  [3];
    logic [9:0]  rem_reg  [3];
    logic [7:0]  root_reg [3];
    logic [2:0]  step_reg;
    logic        out_valid_reg;
    logic [7:0]  mag_reg  [3];
    logic        fend_out_reg;

    logic [10:0] pos_x [3], neg_x [3], pos_y [3], neg_y [3];
    logic [11:0] dx [3], dy [3];
    logic [20:0] sq [3];
    logic [10:0] remsh [3], trial [3];
    logic [7:0]  mag   [3];
    logic [7:0]  p     [3][9];
    logic        load_out;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p[ch][i] = work_reg.win[i][(2 - ch) * 8 +: 8];
            end
            pos_x[ch] = 11'(p[ch][2]) + {2'b00, p[ch][5], 1'b0} + 11'(p[ch][8]);
            neg_x[ch] = 11'(p[ch][0]) + {2'b00, p[ch][3], 1'b0} + 11'(p[ch][6]);
            pos_y[ch] = 11'(p[ch][6]) + {2'b00, p[ch][7], 1'b0} + 11'(p[ch][8]);
            neg_y[ch] = 11'(p[ch][0]) + {2'b00, p[ch][1], 1'b0} + 11'(p[ch][2]);
            dx[ch] = {1'b0, pos_x[ch]} - {1'b0, neg_x[ch]};
            dy[ch] = {1'b0, pos_y[ch]} - {1'b0, neg_y[ch]};
            sq[ch] = 21'({10'd0, gx_reg[ch]} * {10'd0, gx_reg[ch]}) +
                     21'({10'd0, gy_reg[ch]} * {10'd0, gy_reg[ch]});
            // one root digit: bring down two bits and try (root << 2) | 1
            remsh[ch] = {rem_reg[ch][8:0], s_reg[ch][{step_reg, 1'b0} +: 2]};
            trial[ch] = {1'b0, root_reg[ch], 2'b01};
            mag[ch]   = big_reg[ch] ? sem_pkg::MAG_SAT :
                        (rem_reg[ch] > {2'b00, root_reg[ch]}) ? root_reg[ch] + 8'd1
                                                              : root_reg[ch];
        end
    end

    assign load_out = (state_reg == sem_pkg::B_OUT) && (!out_valid_reg || edge_out.ready);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            sem_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = sem_pkg::B_SUM;
                end
            end
            sem_pkg::B_SUM:  state_next = sem_pkg::B_SQ;
            sem_pkg::B_SQ:   state_next = sem_pkg::B_ROOT;
            sem_pkg::B_ROOT:
            begin
                if (step_reg == 3'd0)
                begin
                    state_next = sem_pkg::B_OUT;
                end
            end
            sem_pkg::B_OUT:
            begin
                if (load_out)
                begin
                    state_next = sem_pkg::B_IDLE;
                end
            end
            default:         state_next = sem_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= pop_data;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (state_reg == sem_pkg::B_SUM)
            begin
                gx_reg[ch] <= dx[ch][11] ? 10'(-dx[ch]) : dx[ch][9:0];
                gy_reg[ch] <= dy[ch][11] ? 10'(-dy[ch]) : dy[ch][9:0];
            end
            if (state_reg == sem_pkg::B_SQ)
            begin
                s_reg[ch]    <= sq[ch][15:0];
                big_reg[ch]  <= sq[ch] > sem_pkg::MAG_LIMIT;
                rem_reg[ch]  <= '0;
                root_reg[ch] <= '0;
            end
            if (state_reg == sem_pkg::B_ROOT)
            begin
                if (remsh[ch] >= trial[ch])
                begin
                    rem_reg[ch]  <= 10'(remsh[ch] - trial[ch]);
                    root_reg[ch] <= {root_reg[ch][6:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch]  <= remsh[ch][9:0];
                    root_reg[ch] <= {root_reg[ch][6:0], 1'b0};
                end
            end
            if (load_out)
            begin
                mag_reg[ch] <= mag[ch];
            end
        end
        if (state_reg == sem_pkg::B_SQ)
        begin
            step_reg <= 3'd7;
        end
        else if (state_reg == sem_pkg::B_ROOT)
        begin
            step_reg <= step_reg - 3'd1;
        end
        if (load_out)
        begin
            fend_out_reg <= work_reg.fend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sem_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (edge_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign edge_out.valid      = out_valid_reg;
    assign edge_out.red_edge   = mag_reg[0];
    assign edge_out.green_edge = mag_reg[1];
    assign edge_out.blue_edge  = mag_reg[2];
    assign edge_out.frame_end  = fend_out_reg;

endmodule

/* rtl/sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 Sobel edge magnitude per RGB channel over a raster pixel stream.
// ----------------------------------------------------------------------------
// The front takes a pixel only while idle with the queue not full, reads the
// line stores, then writes back and shifts the window before the next pixel.
// Each result then passes the back unit: pop, sums, squares, an eight-step
// root at one digit per cycle and an output load that waits on a stall; the
// back pops again only after that load. The two-entry queue lets the front run ahead.
// Results lag by one row plus one pixel; frame_width+1 filler transactions
// after the last pixel flush the frame. A filler mid-frame is dropped.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    sem_pix_if.sink     pix_in,
    sem_edge_if.source  edge_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    sem_pkg::frame_size_t size;
    sem_pkg::q_push_t     q_push;
    sem_pkg::work_t       pop_data;
    logic q_full, q_empty, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::FRAME_W_RESET;
            height_reg <= sem_pkg::FRAME_H_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sem_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                sem_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            size.w = 11'd1;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            size.w = 11'(MAX_WIDTH);
        end
        else
        begin
            size.w = width_reg;
        end
        size.h = (height_reg == 12'd0) ? 12'd1 : height_reg;
    end

    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in),
        .size   (size),
        .q_full (q_full),
        .q_push (q_push)
    );

    sem_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .pop_data (pop_data),
        .full     (q_full),
        .empty    (q_empty)
    );

    sem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop      (pop),
        .pop_data (pop_data),
        .edge_out (edge_out)
    );

endmodule

/* rtl/sem_checker.sv */
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks on the edge output of the Sobel block.
// ----------------------------------------------------------------------------
module sem_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [24:0] out_data
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("edge transaction dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("edge payload changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("edge output valid during reset");

    a_first_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("edge output valid straight after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (edge_out.valid),
    .out_ready (edge_out.ready),
    .out_data  ({edge_out.red_edge, edge_out.green_edge, edge_out.blue_edge,
                 edge_out.frame_end})
);

/* dv/sem_tb_ifs.sv */
// ----------------------------------------------------------------------------
// sem_tb_ifs
// Testbench side notes on the pixel and edge channels.
// ----------------------------------------------------------------------------
// The channel interfaces come from the RTL file list; this file holds the
// result record used by the scoreboard.
package sem_tb_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } edge_rec_t;

endpackage

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Random and directed pixel streams through the Sobel edge block, with the
// results compared against an in-bench model of the window and line stores.
// ----------------------------------------------------------------------------
class edge_scoreboard;
    int unsigned width_reg;
    int unsigned height_reg;
    logic [23:0] upper_line [1024];
    logic [23:0] middle_line [1024];
    logic [23:0] win [9];
    int unsigned col_pos;
    int unsigned row_pos;
    sem_tb_pkg::edge_rec_t pending [$];
    int          errors;

    function new();
        width_reg  = sem_pkg::FRAME_W_RESET;
        height_reg = sem_pkg::FRAME_H_RESET;
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        errors  = 0;
    endfunction

    function void set_reg(logic idx, int unsigned val);
        if (idx == sem_pkg::CFG_FRAME_WIDTH)
            width_reg = val & 'h7FF;
        else
            height_reg = val & 'hFFF;
    endfunction

    function int unsigned root_round(int unsigned s);
        int unsigned n;
        int unsigned t;
        n = 0;
        if (s > 65280)
            return 255;
        for (int b = 7; b >= 0; b--)
        begin
            t = n | (1 << b);
            if (t * t <= s)
                n = t;
        end
        if (s - n * n > n)
            n++;
        return (n > 255) ? 255 : n;
    endfunction

    function logic [7:0] channel_mag(int sh, bit mt, bit mb, bit ml, bit mr);
        int gx;
        int gy;
        int v;
        int kx [9];
        int ky [9];
        kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
        ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && mt) || (r == 2 && mb) || (c == 0 && ml) || (c == 2 && mr))
                    continue;
                v = (win[r * 3 + c] >> sh) & 8'hFF;
                gx += v * kx[r * 3 + c];
                gy += v * ky[r * 3 + c];
            end
        return 8'(root_round(gx * gx + gy * gy));
    endfunction

    function void note_pixel(logic [7:0] r_in, logic [7:0] g_in, logic [7:0] b_in,
                             logic fill);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned crow;
        int unsigned ccol;
        logic [23:0] pix;
        logic [23:0] up;
        logic [23:0] mid;
        bit flushing;
        bit emit;
        sem_tb_pkg::edge_rec_t rec;
        w = (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        flushing = row_pos >= h;
        if (fill && !flushing)
            return;
        pix = flushing ? 24'h0 : {r_in, g_in, b_in};
        idx = (col_pos < 1024) ? col_pos : 1023;
        up  = upper_line[idx];
        mid = middle_line[idx];
        upper_line[idx]  = mid;
        middle_line[idx] = pix;
        for (int r = 0; r < 3; r++)
        begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = pix;
        emit = row_pos >= 2 || (row_pos >= 1 && col_pos >= 1);
        if (col_pos == 0)
        begin
            crow = (row_pos >= 2) ? row_pos - 2 : 0;
            ccol = w - 1;
        end
        else
        begin
            crow = row_pos - ((row_pos >= 1) ? 1 : 0);
            ccol = col_pos - 1;
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (!emit)
            return;
        rec.red   = channel_mag(16, crow == 0, crow + 1 >= h, ccol == 0, ccol + 1 >= w);
        rec.green = channel_mag(8, crow == 0, crow + 1 >= h, ccol == 0, ccol + 1 >= w);
        rec.blue  = channel_mag(0, crow == 0, crow + 1 >= h, ccol == 0, ccol + 1 >= w);
        rec.fend  = (crow + 1 >= h) && (ccol + 1 >= w);
        pending.push_back(rec);
        if (rec.fend)
        begin
            col_pos = 0;
            row_pos = 0;
        end
    endfunction

    function void check_edge(sem_tb_pkg::edge_rec_t got);
        sem_tb_pkg::edge_rec_t exp_rec;
        if (pending.size() == 0)
        begin
            report("unexpected result", got, got);
            return;
        end
        exp_rec = pending.pop_front();
        if (got !== exp_rec)
            report("field mismatch", got, exp_rec);
    endfunction

    function void report(string what, sem_tb_pkg::edge_rec_t got,
                         sem_tb_pkg::edge_rec_t want);
        errors++;
        $display("MISMATCH %s: got r%0d g%0d b%0d e%0d, want r%0d g%0d b%0d e%0d", what,
                 got.red, got.green, got.blue, got.fend,
                 want.red, want.green, want.blue, want.fend);
    endfunction
endclass

module testbench;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          ramp_left;

    sem_pix_if  pix_ch ();
    sem_edge_if edge_ch ();

    edge_scoreboard sb;

    sobel_edge_magnitude_rgb uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_ch.sink),
        .edge_out (edge_ch.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random stall, checks every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (edge_ch.valid && edge_ch.ready)
                sb.check_edge({edge_ch.red_edge, edge_ch.green_edge,
                               edge_ch.blue_edge, edge_ch.frame_end});
            edge_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 12'(val);
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fill);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(posedge clk);
            pix_ch.valid <= 1'b0;
        end
        @(posedge clk);
        pix_ch.valid   <= 1'b1;
        pix_ch.red_in  <= r;
        pix_ch.green_in <= g;
        pix_ch.blue_in <= b;
        pix_ch.filler  <= fill;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        sb.note_pixel(r, g, b, fill);
        pix_ch.valid <= 1'b0;
    endtask

    // wait with the source idle until everything predicted has come back
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // one frame: pixels then the flush; mode 0 random, 1 extremes, 2 with noise
    task automatic run_frame(int unsigned w, int unsigned h, int mode);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int i = 0; i < w * h; i++)
        begin
            if (mode == 1)
            begin
                r = (i % 2) ? 8'hFF : 8'h00;
                g = (i % 3) ? 8'h00 : 8'hFF;
                b = ((i / w) % 2) ? 8'hFF : 8'h00;
            end
            else
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
            if (mode == 2 && $urandom_range(9) == 0)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            send_pixel(r, g, b, 1'b0);
        end
        for (int i = 0; i <= w; i++)
        begin
            // a pixel during flush counts as a filler
            if (mode == 2 && $urandom_range(3) == 0)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        end
    endtask

    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int unsigned w;
        int unsigned h;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sem_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.red_in = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in = '0;
        pix_ch.filler = 1'b0;
        edge_ch.ready = 1'b0;
        src_idle_pct = 25;
        snk_idle_pct = 51;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: smallest frame, extremes, filler before any pixel
        write_reg(sem_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, 1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        run_frame(1, 1, 1);
        drain();
        write_reg(sem_pkg::CFG_FRAME_WIDTH, 4);
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, 3);
        run_frame(4, 3, 1);
        drain();
        // zero width and zero height act as one
        write_reg(sem_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, 0);
        run_frame(1, 1, 0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 25 : ((phase == 1) ? 51 : 0);
            snk_idle_pct = (phase == 0) ? 51 : ((phase == 1) ? 25 : 0);
            ramp_left = 630;
            while (ramp_left > 0)
            begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 8);
                if ($urandom_range(5) == 0)
                    w = $urandom_range(20, 40);
                write_reg(sem_pkg::CFG_FRAME_WIDTH, w);
                write_reg(sem_pkg::CFG_FRAME_HEIGHT, h);
                run_frame(w, h, ($urandom_range(3) == 0) ? 2 : 0);
                ramp_left = ramp_left - int'(w * h + w + 1);
                drain();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* sobel_edge_magnitude_rgb.f */
rtl/sem_pkg.sv
rtl/sem_ifs.sv
rtl/sem_front.sv
rtl/sem_fifo.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude_rgb.sv
rtl/sem_checker.sv
dv/sem_tb_ifs.sv
dv/testbench.sv
